/* rtl/stack_vm_instruction_execute_macros.svh */
// assertion macros used by the checker file
`ifndef STACK_VM_INSTRUCTION_EXECUTE_MACROS_SVH
`define STACK_VM_INSTRUCTION_EXECUTE_MACROS_SVH

// clocked property, off while reset is held
`define SVM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked property, also checked in reset
`define SVM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* rtl/svm_pkg.sv */
// types and codes of the stack machine executor
package svm_pkg;

  typedef enum logic [5:0] {
    OP_LEA  = 6'd0,  OP_IMM  = 6'd1,  OP_JMP  = 6'd2,  OP_CALL = 6'd3,
    OP_JZ   = 6'd4,  OP_JNZ  = 6'd5,  OP_ENT  = 6'd6,  OP_ADJ  = 6'd7,
    OP_LEV  = 6'd8,  OP_LI   = 6'd9,  OP_LC   = 6'd10, OP_SI   = 6'd11,
    OP_SC   = 6'd12, OP_PUSH = 6'd13, OP_OR   = 6'd14, OP_XOR  = 6'd15,
    OP_AND  = 6'd16, OP_EQ   = 6'd17, OP_NE   = 6'd18, OP_LT   = 6'd19,
    OP_GT   = 6'd20, OP_LE   = 6'd21, OP_GE   = 6'd22, OP_SHL  = 6'd23,
    OP_SHR  = 6'd24, OP_ADD  = 6'd25, OP_SUB  = 6'd26, OP_MUL  = 6'd27,
    OP_DIV  = 6'd28, OP_MOD  = 6'd29, OP_EXIT = 6'd37
  } svm_op_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_EXIT    = 3'd1,
    ST_UNKNOWN = 3'd2,
    ST_DIVZERO = 3'd3,
    ST_BADADDR = 3'd4
  } svm_status_e;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DECODE, S_RD1, S_RD2, S_MUL, S_DIV, S_DIVF, S_DONE
  } svm_state_e;

  typedef struct packed {
    logic [5:0]         cmd;
    logic signed [63:0] operand;
  } svm_req_t;

  typedef struct packed {
    logic [15:0]        next_pc;
    logic signed [63:0] acc_value;
    logic [2:0]         status;
    logic signed [63:0] exit_value;
  } svm_res_t;

endpackage

/* rtl/svm_ram.sv */
// generic single write, single read ram with registered read
module svm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8192
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* rtl/stack_vm_instruction_execute.sv */
// stack machine instruction executor, top level
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-----------------------------
//  in      | to block  | in_valid_i / in_stall_o | in_req_i  (cmd, operand)
//  out     | from block| out_valid_o/ out_stall_i| out_res_o (pc, acc, status, exit)
//
// one instruction at a time: register-only ops finish in decode, ops that read
// one word (pops, loads, si, exit) in the first read, sc and lev (two reads, dependent for sc)
// in the second, mul (three 32x32 partial products) and div and mod (radix-2 divider, 64 steps) in their own states.
// the data ram has a single read port with a registered read.
// after reset every ram word is swept to zero, with the input stalled.
// a finished result sits in the output register; a new request is taken meanwhile.
module stack_vm_instruction_execute
  import svm_pkg::*;
#(
  parameter int MEM_BYTES  = 65536,
  parameter int TEXT_WORDS = 65536
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  svm_req_t in_req_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output svm_res_t out_res_o
);

  localparam int MEM_WORDS = MEM_BYTES / 8;
  localparam int MEM_TOP   = MEM_WORDS * 8;
  localparam int WW        = $clog2(MEM_WORDS);
  localparam int AW        = $clog2(MEM_TOP) + 1;
  localparam int TEXT_LIM  = (TEXT_WORDS < 65536) ? TEXT_WORDS : 65536;

  localparam logic [63:0] TOP64   = 64'(MEM_TOP);
  localparam logic [63:0] WORDS64 = 64'(MEM_WORDS);
  localparam logic [63:0] TL64    = 64'(TEXT_LIM);
  localparam logic [16:0] TL17    = 17'(TEXT_LIM);
  localparam logic [WW-1:0] LAST_WORD = WW'(MEM_WORDS - 1);

  svm_state_e  state_q, state_d;
  logic [63:0] acc_q;
  logic [AW-1:0] bp_q, sp_q;
  logic [15:0] pc_q;
  logic        halted_q;
  svm_status_e res_status_q;
  logic [63:0] res_ev_q;
  logic [5:0]  cmd_q;
  logic [63:0] arg_q, l_q, t_q, mul_q;
  logic [1:0]  mstep_q;
  logic [63:0] dq_q, rem_q, dvs_q;
  logic        ngq_q, ngr_q;
  logic [5:0]  dcnt_q;
  logic [WW-1:0] clr_cnt_q;
  logic        out_valid_q;
  svm_res_t    out_res_q;

  svm_op_e     op;
  logic [63:0] rdata;

  // finishing step of an instruction
  logic        fin;
  svm_status_e f_st;
  logic [63:0] f_acc, f_ev;
  logic [AW-1:0] f_bp, f_sp;
  logic [15:0] f_pc;
  logic [WW-1:0] rd_addr, wr_addr;
  logic        wr_en;
  logic [63:0] wr_data;

  logic [63:0] sp64, bp64, arg8, arg_mag, ent_t, adj_t;
  logic [AW-1:0] sp_m8, sp_p8;
  logic [16:0] pc1, pc2;
  logic [15:0] np1, np2;
  logic        sp_empty, sp_lt8, span_ok, taken;
  logic [63:0] alu, byte_w, merged;
  logic [5:0]  bsh;
  logic [63:0] mul_p;
  logic [31:0] mx_a, mx_b;
  logic [63:0] dsh, dsub;
  logic        dge;
  logic [63:0] l_mag, a_mag, qv, rv;
  logic        out_free;

  assign op = svm_op_e'(cmd_q);

  assign sp64     = 64'(sp_q);
  assign bp64     = 64'(bp_q);
  assign arg8     = arg_q << 3;
  assign arg_mag  = arg_q[63] ? (64'd0 - arg_q) : arg_q;
  assign span_ok  = arg_mag <= WORDS64;
  assign ent_t    = sp64 - 64'd8 - arg8;
  assign adj_t    = sp64 + arg8;
  assign sp_m8    = sp_q - AW'(8);
  assign sp_p8    = sp_q + AW'(8);
  assign sp_empty = sp64 >= TOP64;
  assign sp_lt8   = sp_q < AW'(8);
  assign taken    = (op == OP_JZ) == (acc_q == 64'd0);

  // sequential pc wraps at the text limit
  assign pc1 = {1'b0, pc_q} + 17'd1;
  assign pc2 = {1'b0, pc_q} + 17'd2;
  assign np1 = (pc1 == TL17) ? 16'd0 : pc1[15:0];
  assign np2 = (pc2 >= TL17) ? 16'(pc2 - TL17) : pc2[15:0];

  // popped left operand against the accumulator
  always_comb begin
    case (op)
      OP_OR:   alu = rdata | acc_q;
      OP_XOR:  alu = rdata ^ acc_q;
      OP_AND:  alu = rdata & acc_q;
      OP_EQ:   alu = 64'(rdata == acc_q);
      OP_NE:   alu = 64'(rdata != acc_q);
      OP_LT:   alu = 64'($signed(rdata) < $signed(acc_q));
      OP_GT:   alu = 64'($signed(acc_q) < $signed(rdata));
      OP_LE:   alu = 64'(!($signed(acc_q) < $signed(rdata)));
      OP_GE:   alu = 64'(!($signed(rdata) < $signed(acc_q)));
      OP_SHL:  alu = rdata << acc_q[5:0];
      OP_SHR:  alu = 64'($signed(rdata) >>> acc_q[5:0]);
      OP_ADD:  alu = rdata + acc_q;
      OP_SUB:  alu = rdata - acc_q;
      default: alu = rdata;
    endcase
  end

  assign byte_w = rdata >> {acc_q[2:0], 3'b000};
  assign bsh    = {t_q[2:0], 3'b000};
  assign merged = (rdata & ~(64'hFF << bsh)) | (64'(acc_q[7:0]) << bsh);

  // shared 32x32 multiplier, one partial product a cycle
  always_comb begin
    case (mstep_q)
      2'd0:    begin mx_a = l_q[31:0];  mx_b = acc_q[31:0];  end
      2'd1:    begin mx_a = l_q[31:0];  mx_b = acc_q[63:32]; end
      default: begin mx_a = l_q[63:32]; mx_b = acc_q[31:0];  end
    endcase
  end
  assign mul_p = 64'(mx_a) * 64'(mx_b);

  // restoring divider step on magnitudes
  assign dsh   = {rem_q[62:0], dq_q[63]};
  assign dge   = dsh >= dvs_q;
  assign dsub  = dsh - dvs_q;
  assign l_mag = rdata[63] ? (64'd0 - rdata) : rdata;
  assign a_mag = acc_q[63] ? (64'd0 - acc_q) : acc_q;
  assign qv    = ngq_q ? (64'd0 - dq_q) : dq_q;
  assign rv    = ngr_q ? (64'd0 - rem_q) : rem_q;

  // datapath per step
  always_comb begin
    fin     = 1'b0;
    f_st    = ST_OK;
    f_acc   = acc_q;
    f_bp    = bp_q;
    f_sp    = sp_q;
    f_pc    = np1;
    f_ev    = 64'd0;
    rd_addr = sp_q[WW+2:3];
    wr_en   = 1'b0;
    wr_addr = sp_m8[WW+2:3];
    wr_data = acc_q;
    unique case (state_q)
      S_DECODE: begin
        if (!halted_q) begin
          unique case (op) inside
            OP_LEA: begin
              fin = 1'b1; f_acc = bp64 + arg8; f_pc = np2;
            end
            OP_IMM: begin
              fin = 1'b1; f_acc = arg_q; f_pc = np2;
            end
            OP_JMP: begin
              fin = 1'b1;
              if (arg_q >= TL64) f_st = ST_BADADDR;
              else f_pc = arg_q[15:0];
            end
            OP_JZ, OP_JNZ: begin
              fin = 1'b1;
              if (!taken) f_pc = np2;
              else if (arg_q >= TL64) f_st = ST_BADADDR;
              else f_pc = arg_q[15:0];
            end
            OP_CALL: begin
              fin = 1'b1;
              if (arg_q >= TL64 || sp_lt8) begin
                f_st = ST_BADADDR;
              end else begin
                f_sp = sp_m8; wr_en = 1'b1; wr_data = 64'(np2); f_pc = arg_q[15:0];
              end
            end
            OP_ENT: begin
              fin = 1'b1;
              if (sp_lt8 || !span_ok || ent_t > TOP64) begin
                f_st = ST_BADADDR;
              end else begin
                wr_en = 1'b1; wr_data = bp64; f_bp = sp_m8;
                f_sp = ent_t[AW-1:0]; f_pc = np2;
              end
            end
            OP_ADJ: begin
              fin = 1'b1;
              if (!span_ok || adj_t > TOP64) f_st = ST_BADADDR;
              else begin
                f_sp = adj_t[AW-1:0]; f_pc = np2;
              end
            end
            OP_LEV: begin
              if (bp_q[2:0] != 3'd0 || bp64 > TOP64 - 64'd16) begin
                fin = 1'b1; f_st = ST_BADADDR;
              end else begin
                rd_addr = bp_q[WW+2:3];
              end
            end
            OP_LI: begin
              if (acc_q[2:0] != 3'd0 || acc_q >= TOP64) begin
                fin = 1'b1; f_st = ST_BADADDR;
              end else begin
                rd_addr = acc_q[WW+2:3];
              end
            end
            OP_LC: begin
              if (acc_q >= TOP64) begin
                fin = 1'b1; f_st = ST_BADADDR;
              end else begin
                rd_addr = acc_q[WW+2:3];
              end
            end
            OP_SI, OP_SC, OP_EXIT, [OP_OR:OP_MOD]: begin
              if (sp_empty) begin
                fin = 1'b1; f_st = ST_BADADDR;
              end
            end
            OP_PUSH: begin
              fin = 1'b1;
              if (sp_lt8) f_st = ST_BADADDR;
              else begin
                wr_en = 1'b1; f_sp = sp_m8;
              end
            end
            default: begin
              fin = 1'b1; f_st = ST_UNKNOWN;
            end
          endcase
        end
      end
      S_RD1: begin
        unique case (op) inside
          OP_MUL: ;
          OP_DIV, OP_MOD: begin
            if (acc_q == 64'd0) begin
              fin = 1'b1; f_st = ST_DIVZERO;
            end
          end
          [OP_OR:OP_SUB]: begin
            fin = 1'b1; f_acc = alu; f_sp = sp_p8;
          end
          OP_LI: begin
            fin = 1'b1; f_acc = rdata;
          end
          OP_LC: begin
            fin = 1'b1; f_acc = {{56{byte_w[7]}}, byte_w[7:0]};
          end
          OP_EXIT: begin
            fin = 1'b1; f_st = ST_EXIT; f_ev = rdata;
          end
          OP_SI: begin
            fin = 1'b1;
            if (rdata[2:0] != 3'd0 || rdata >= TOP64) f_st = ST_BADADDR;
            else begin
              wr_en = 1'b1; wr_addr = rdata[WW+2:3]; f_sp = sp_p8;
            end
          end
          OP_SC: begin
            if (rdata >= TOP64) begin
              fin = 1'b1; f_st = ST_BADADDR;
            end else begin
              rd_addr = rdata[WW+2:3];
            end
          end
          OP_LEV: rd_addr = bp_q[WW+2:3] + WW'(1);
          default: ;
        endcase
      end
      S_RD2: begin
        fin = 1'b1;
        if (op == OP_SC) begin
          wr_en = 1'b1; wr_addr = t_q[WW+2:3]; wr_data = merged;
          f_acc = {{56{acc_q[7]}}, acc_q[7:0]}; f_sp = sp_p8;
        end else if (t_q[2:0] != 3'd0 || t_q > TOP64 || rdata >= TL64) begin
          f_st = ST_BADADDR;
        end else begin
          f_sp = bp_q + AW'(16); f_bp = t_q[AW-1:0]; f_pc = rdata[15:0];
        end
      end
      S_MUL: begin
        if (mstep_q == 2'd3) begin
          fin = 1'b1; f_acc = mul_q; f_sp = sp_p8;
        end
      end
      S_DIVF: begin
        fin = 1'b1; f_sp = sp_p8;
        f_acc = (op == OP_DIV) ? qv : rv;
      end
      default: ;
    endcase
  end

  assign out_free = !out_valid_q || !out_stall_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR:  if (clr_cnt_q == LAST_WORD) state_d = S_IDLE;
      S_IDLE:   if (in_valid_i) state_d = S_DECODE;
      S_DECODE: state_d = (halted_q || fin) ? S_DONE : S_RD1;
      S_RD1: begin
        if (fin) state_d = S_DONE;
        else if (op == OP_MUL) state_d = S_MUL;
        else if (op == OP_DIV || op == OP_MOD) state_d = S_DIV;
        else state_d = S_RD2;
      end
      S_RD2:    state_d = S_DONE;
      S_MUL:    if (mstep_q == 2'd3) state_d = S_DONE;
      S_DIV:    if (dcnt_q == 6'd63) state_d = S_DIVF;
      S_DIVF:   state_d = S_DONE;
      S_DONE:   if (out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_cnt_q    <= '0;
      acc_q        <= 64'd0;
      bp_q         <= AW'(MEM_TOP);
      sp_q         <= AW'(MEM_TOP);
      pc_q         <= 16'd0;
      halted_q     <= 1'b0;
      res_status_q <= ST_OK;
      res_ev_q     <= 64'd0;
      out_valid_q  <= 1'b0;
      mstep_q      <= 2'd0;
      dcnt_q       <= 6'd0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) clr_cnt_q <= clr_cnt_q + WW'(1);
      if (fin) begin
        if (f_st == ST_OK || f_st == ST_EXIT) begin
          acc_q <= f_acc;
          bp_q  <= f_bp;
          sp_q  <= f_sp;
          pc_q  <= f_pc;
        end
        if (f_st != ST_OK) halted_q <= 1'b1;
        res_status_q <= f_st;
        res_ev_q     <= f_ev;
      end else if (state_q == S_DECODE && !halted_q) begin
        res_status_q <= ST_OK;
        res_ev_q     <= 64'd0;
      end
      if (state_q == S_RD1) mstep_q <= 2'd0;
      else if (state_q == S_MUL) mstep_q <= mstep_q + 2'd1;
      if (state_q == S_RD1) dcnt_q <= 6'd0;
      else if (state_q == S_DIV) dcnt_q <= dcnt_q + 6'd1;
      if (state_q == S_DONE && out_free) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      cmd_q <= in_req_i.cmd;
      arg_q <= in_req_i.operand;
    end
    if (state_q == S_RD1) begin
      l_q   <= rdata;
      t_q   <= rdata;
      dq_q  <= l_mag;
      rem_q <= 64'd0;
      dvs_q <= a_mag;
      ngq_q <= rdata[63] ^ acc_q[63];
      ngr_q <= rdata[63];
    end
    if (state_q == S_MUL) begin
      if (mstep_q == 2'd0) mul_q <= mul_p;
      else if (mstep_q != 2'd3) mul_q[63:32] <= mul_q[63:32] + mul_p[31:0];
    end
    if (state_q == S_DIV) begin
      dq_q  <= {dq_q[62:0], dge};
      rem_q <= dge ? dsub : dsh;
    end
    if (state_q == S_DONE && out_free) begin
      out_res_q.next_pc    <= pc_q;
      out_res_q.acc_value  <= acc_q;
      out_res_q.status     <= res_status_q;
      out_res_q.exit_value <= res_ev_q;
    end
  end

  logic          ram_we;
  logic [WW-1:0] ram_waddr;
  logic [63:0]   ram_wdata;

  assign ram_we    = (state_q == S_CLEAR) || wr_en;
  assign ram_waddr = (state_q == S_CLEAR) ? clr_cnt_q : wr_addr;
  assign ram_wdata = (state_q == S_CLEAR) ? 64'd0 : wr_data;

  svm_ram #(
    .WIDTH(64),
    .DEPTH(MEM_WORDS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(rd_addr),
    .rdata_o(rdata)
  );

endmodule

/* rtl/svm_checker.sv */
// port checker for the stack machine executor, bound to the top level
`include "stack_vm_instruction_execute_macros.svh"

module svm_checker
  import svm_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_stall_o,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input svm_res_t out_res_o
);

  logic       last_bad_q;
  logic [2:0] last_status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_bad_q    <= 1'b0;
      last_status_q <= 3'd0;
    end else if (out_valid_o && !out_stall_i && out_res_o.status != ST_OK
                 && !last_bad_q) begin
      last_bad_q    <= 1'b1;
      last_status_q <= out_res_o.status;
    end
  end

  `SVM_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o, "result dropped under stall")
  `SVM_ASSERT(a_one_at_a_time, in_valid_i && !in_stall_o |=> in_stall_o, "second request taken too early")
  `SVM_ASSERT(a_halt_sticks, out_valid_o && last_bad_q |-> out_res_o.status == last_status_q, "halt status changed")
  `SVM_ASSERT(a_exit_value, out_valid_o && out_res_o.status != ST_EXIT |-> out_res_o.exit_value == 64'sd0, "exit value without exit")
  `SVM_ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> !out_valid_o, "result shown in reset")

endmodule

bind stack_vm_instruction_execute svm_checker u_svm_checker (.*);

/* sim/stack_vm_instruction_execute_tb.sv */
// self-checking testbench of the stack machine instruction executor
`timescale 1ns / 1ps

module stack_vm_instruction_execute_tb;
  import svm_pkg::*;

  localparam logic [63:0] MEM_TOP = 64'd65536;
  localparam logic [63:0] MIN64 = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MAX64 = 64'h7fff_ffff_ffff_ffff;

  class vm_scoreboard;
    logic [63:0] acc, fbase, sp, mem [8192];
    logic [15:0] pc;
    bit halted;
    svm_status_e halt_st;
    logic [63:0] halt_ev;
    svm_res_t pending_res[$];
    int errors;

    function new();
      acc = 0; fbase = MEM_TOP; sp = MEM_TOP; pc = 0;
      halted = 0; halt_st = ST_OK; halt_ev = 0; errors = 0;
      foreach (mem[i]) mem[i] = 0;
    endfunction

    // runs one instruction; state changes only when commit is set
    function svm_res_t execute(svm_req_t rq, bit commit);
      logic [63:0] arg, na, nb, ns, l, t, q, ev, wd, m;
      logic [15:0] np, np2;
      logic [7:0] b;
      svm_status_e st;
      bit we, ok;
      int unsigned wi;
      svm_res_t r;
      if (halted) begin
        r.next_pc = pc; r.acc_value = acc; r.status = halt_st; r.exit_value = halt_ev;
        return r;
      end
      arg = rq.operand; na = acc; nb = fbase; ns = sp;
      np = pc + 16'd1; np2 = pc + 16'd2;
      st = ST_OK; ev = 0; l = 0; we = 0; wi = 0; wd = 0;
      // binary operators pop their left operand first
      if (rq.cmd >= OP_OR && rq.cmd <= OP_MOD) begin
        if (ns >= MEM_TOP) st = ST_BADADDR;
        else begin l = mem[ns[15:3]]; ns += 8; end
      end
      if (st == ST_OK) begin
        case (rq.cmd)
          OP_LEA: begin na = nb + (arg << 3); np = np2; end
          OP_IMM: begin na = arg; np = np2; end
          OP_JMP: if (arg > 64'd65535) st = ST_BADADDR; else np = arg[15:0];
          OP_JZ, OP_JNZ: begin
            if ((rq.cmd == OP_JZ) == (na == 0)) begin
              if (arg > 64'd65535) st = ST_BADADDR; else np = arg[15:0];
            end else np = np2;
          end
          OP_CALL: begin
            if (arg > 64'd65535 || ns < 8) st = ST_BADADDR;
            else begin
              ns -= 8; we = 1; wi = ns[15:3]; wd = {48'd0, np2}; np = arg[15:0];
            end
          end
          OP_ENT, OP_ADJ: begin
            m = arg[63] ? -arg : arg;
            if (m > 64'd8192 || (rq.cmd == OP_ENT && ns < 8)) st = ST_BADADDR;
            else begin
              t = (rq.cmd == OP_ENT) ? ns - 8 - (arg << 3) : ns + (arg << 3);
              if (t > MEM_TOP) st = ST_BADADDR;
              else begin
                if (rq.cmd == OP_ENT) begin
                  ns -= 8; we = 1; wi = ns[15:3]; wd = nb; nb = ns;
                end
                ns = t; np = np2;
              end
            end
          end
          OP_LEV: begin
            if (nb[2:0] != 0 || nb > MEM_TOP - 16) st = ST_BADADDR;
            else begin
              t = mem[nb[15:3]];
              q = mem[nb[15:3] + 1];
              if (t[2:0] != 0 || t > MEM_TOP || q > 64'd65535) st = ST_BADADDR;
              else begin ns = nb + 16; nb = t; np = q[15:0]; end
            end
          end
          OP_LI: begin
            if (na[2:0] != 0 || na >= MEM_TOP) st = ST_BADADDR;
            else na = mem[na[15:3]];
          end
          OP_LC: begin
            if (na >= MEM_TOP) st = ST_BADADDR;
            else begin
              wd = mem[na[15:3]];
              b = wd[{na[2:0], 3'b000} +: 8];
              na = {{56{b[7]}}, b};
            end
          end
          OP_SI, OP_SC: begin
            if (ns >= MEM_TOP) st = ST_BADADDR;
            else begin
              t = mem[ns[15:3]];
              if (t >= MEM_TOP || (rq.cmd == OP_SI && t[2:0] != 0)) st = ST_BADADDR;
              else begin
                we = 1; wi = t[15:3]; ns += 8;
                if (rq.cmd == OP_SI) wd = na;
                else begin
                  wd = mem[wi];
                  wd[{t[2:0], 3'b000} +: 8] = na[7:0];
                  na = {{56{na[7]}}, na[7:0]};
                end
              end
            end
          end
          OP_PUSH: begin
            if (ns < 8) st = ST_BADADDR;
            else begin ns -= 8; we = 1; wi = ns[15:3]; wd = na; end
          end
          OP_OR:  na = l | na;
          OP_XOR: na = l ^ na;
          OP_AND: na = l & na;
          OP_EQ:  na = (l == na);
          OP_NE:  na = (l != na);
          OP_LT:  na = ($signed(l) < $signed(na));
          OP_GT:  na = ($signed(na) < $signed(l));
          OP_LE:  na = !($signed(na) < $signed(l));
          OP_GE:  na = !($signed(l) < $signed(na));
          OP_SHL: na = l << na[5:0];
          OP_SHR: na = $signed(l) >>> na[5:0];
          OP_ADD: na = l + na;
          OP_SUB: na = l - na;
          OP_MUL: na = l * na;
          OP_DIV, OP_MOD: begin
            if (na == 0) st = ST_DIVZERO;
            else if (l == MIN64 && na == '1) na = (rq.cmd == OP_DIV) ? MIN64 : 64'd0;
            else na = (rq.cmd == OP_DIV) ? $signed(l) / $signed(na) : $signed(l) % $signed(na);
          end
          OP_EXIT: begin
            if (ns >= MEM_TOP) st = ST_BADADDR;
            else begin ev = mem[ns[15:3]]; st = ST_EXIT; end
          end
          default: st = ST_UNKNOWN;
        endcase
      end
      ok = (st == ST_OK || st == ST_EXIT);
      r.next_pc = ok ? np : pc;
      r.acc_value = ok ? na : acc;
      r.status = st;
      r.exit_value = ev;
      if (commit) begin
        if (ok) begin
          acc = na; fbase = nb; sp = ns; pc = np;
          if (we) mem[wi] = wd;
        end
        if (st != ST_OK) begin halted = 1; halt_st = st; halt_ev = ev; end
      end
      return r;
    endfunction

    function void note_request(svm_req_t rq);
      pending_res.push_back(execute(rq, 1));
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      errors++;
      $display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
    endtask

    task check_result(svm_res_t res);
      svm_res_t e;
      if (pending_res.size() == 0) begin
        report("unexpected result, pc", res.next_pc, 0);
        return;
      end
      e = pending_res.pop_front();
      if (res.next_pc !== e.next_pc) report("next_pc", res.next_pc, e.next_pc);
      if (res.acc_value !== e.acc_value) report("acc_value", res.acc_value, e.acc_value);
      if (res.status !== e.status) report("status", res.status, e.status);
      if (res.exit_value !== e.exit_value) report("exit_value", res.exit_value, e.exit_value);
    endtask
  endclass

  logic clk_i = 0, rst_ni = 0;
  logic in_valid_i = 0, out_stall_i = 0;
  svm_req_t in_req_i = '0;
  logic in_stall_o, out_valid_o;
  svm_res_t out_res_o;

  vm_scoreboard sb = new();
  int tx_idle_pct = 31, rx_idle_pct = 56;
  bit long_hold = 0;
  svm_req_t macro_q[$];

  stack_vm_instruction_execute u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_req_i(in_req_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_res_o(out_res_o)
  );

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  function automatic svm_req_t mk(svm_op_e op, logic [63:0] arg);
    svm_req_t rq;
    rq.cmd = op; rq.operand = arg;
    return rq;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] rand_addr();
    return $urandom_range(0, 1) ? 64'($urandom_range(0, 511) * 8)
                                : 64'($urandom_range(0, 65535));
  endfunction

  function automatic logic [63:0] rand_imm();
    case ($urandom_range(0, 5))
      0: return MIN64;
      1: return MAX64;
      2: return 64'(int'($urandom_range(0, 40)) - 20);
      3: return rand_addr();
      default: return rand64();
    endcase
  endfunction

  // next instruction, from short well-formed sequences or a single random opcode
  function automatic svm_req_t next_instr();
    svm_op_e op;
    logic [63:0] a;
    if (macro_q.size() == 0) begin
      case ($urandom_range(0, 9))
        0: begin
          a = rand_addr();
          macro_q = {mk(OP_IMM, a), mk(OP_PUSH, 0), mk(OP_IMM, rand_imm()),
                     mk($urandom_range(0, 1) ? OP_SI : OP_SC, 0)};
        end
        1: macro_q = {mk(OP_IMM, rand_addr()), mk($urandom_range(0, 1) ? OP_LI : OP_LC, 0)};
        2: macro_q = {mk(OP_CALL, $urandom_range(0, 65535)), mk(OP_ENT, $urandom_range(0, 4)),
                      mk(OP_LEA, 64'(int'($urandom_range(0, 6)) - 3)), mk(OP_PUSH, 0),
                      mk(OP_IMM, rand_imm()), mk(svm_op_e'($urandom_range(14, 29)), 0),
                      mk(OP_LEV, 0)};
        3: macro_q = {mk(OP_PUSH, 0), mk(OP_IMM, rand_imm()),
                      mk(svm_op_e'($urandom_range(14, 29)), 0)};
        default: begin
          op = svm_op_e'($urandom_range(0, 29));
          case (op)
            OP_JMP, OP_CALL: a = $urandom_range(0, 65535);
            OP_JZ, OP_JNZ: a = $urandom_range(0, 3) == 0 ? rand64() : $urandom_range(0, 65535);
            OP_ENT: a = $urandom_range(0, 6);
            OP_ADJ: a = (sb.sp < MEM_TOP - 2048) ? (MEM_TOP - sb.sp) >> 3
                                                 : 64'(int'($urandom_range(0, 9)) - 3);
            default: a = rand_imm();
          endcase
          macro_q.push_back(mk(op, a));
        end
      endcase
    end
    return macro_q.pop_front();
  endfunction

  task automatic send(input svm_req_t rq);
    in_req_i <= rq;
    in_valid_i <= 1;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(rq);
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  // a request that would halt the machine is turned into a load immediate
  task automatic send_legal(input svm_req_t rq);
    svm_res_t r;
    r = sb.execute(rq, 0);
    if (r.status != ST_OK) rq = mk(OP_IMM, rand_addr());
    send(rq);
  endtask

  task automatic drain();
    in_valid_i <= 0;
    while (sb.pending_res.size() != 0) @(posedge clk_i);
  endtask

  // receiver side: random stall, plus one long hold-off on request
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (long_hold) begin
        long_hold = 0;
        out_stall_i <= 1;
        repeat (400) @(posedge clk_i);
        out_stall_i <= 0;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < rx_idle_pct);
      end
    end
  end

  always @(posedge clk_i)
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_res_o);

  initial begin
    #5ms;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    svm_req_t directed[$];
    int kind;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1;

    directed = {mk(OP_IMM, MAX64), mk(OP_PUSH, 0), mk(OP_IMM, MIN64), mk(OP_ADD, 0),
                mk(OP_PUSH, 0), mk(OP_IMM, '1), mk(OP_DIV, 0),
                mk(OP_PUSH, 0), mk(OP_IMM, '1), mk(OP_MOD, 0),
                mk(OP_PUSH, 0), mk(OP_IMM, 63), mk(OP_SHR, 0),
                mk(OP_PUSH, 0), mk(OP_IMM, 64'd127), mk(OP_SHL, 0),
                mk(OP_IMM, 64'd5), mk(OP_PUSH, 0), mk(OP_IMM, 64'h180), mk(OP_SC, 0),
                mk(OP_IMM, 64'd5), mk(OP_LC, 0),
                mk(OP_JZ, MIN64), mk(OP_LEA, MIN64), mk(OP_ADJ, 64'd2)};
    foreach (directed[i]) send_legal(directed[i]);

    for (int n = 0; n < 800; n++) begin
      if (n == 270) begin tx_idle_pct = 56; rx_idle_pct = 31; end
      if (n == 400) drain();
      if (n == 540) begin tx_idle_pct = 0; rx_idle_pct = 0; long_hold = 1; end
      send_legal(next_instr());
    end

    // one halting case per run, then requests that must see the halt repeated
    kind = $urandom_range(0, 3);
    case (kind)
      0: begin send(mk(OP_PUSH, 0)); send(mk(OP_EXIT, 0)); end
      1: send(mk(svm_op_e'($urandom_range(0, 1) ? $urandom_range(30, 36)
                                               : $urandom_range(38, 63)), rand64()));
      2: begin send(mk(OP_PUSH, 0)); send(mk(OP_IMM, 0)); send(mk(OP_DIV, 0)); end
      default: begin send(mk(OP_IMM, 64'd3)); send(mk(OP_LI, 0)); end
    endcase
    repeat (10) send(mk(svm_op_e'($urandom_range(0, 63)), rand64()));
    drain();
    repeat (100) @(posedge clk_i);

    if (sb.errors == 0 && sb.pending_res.size() == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
